@@ design/mbb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mbb_pkg;

    // screen geometry and frame store
    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 96;
    localparam int LINE_BYTES    = 20;
    localparam int FRAME_DEPTH   = 1920;
    localparam int ADDR_W        = 11;
    localparam int MAX_SIZE      = 256;

    // one lane per pixel of a source byte
    localparam int NUM_LANES = 8;
    localparam int POS_W     = 3;
    localparam int TOP_BIT   = 7;

    // wide enough for LINE_BYTES * (2 * 255) + 63
    localparam int IDX_W = 15;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_SRC   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    localparam logic [1:0] MODE_COPY  = 2'd0;
    localparam logic [1:0] MODE_AND   = 2'd1;
    localparam logic [1:0] MODE_OR    = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    typedef struct packed {
        logic             hit;
        logic             in_b;
        logic [POS_W-1:0] pos;
        logic             src;
    } lane_t;

    typedef struct packed {
        logic [7:0] mask_a;
        logic [7:0] bits_a;
        logic [7:0] mask_b;
        logic [7:0] bits_b;
    } merge_t;

endpackage

`default_nettype wire

@@ design/mbb_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mbb_lane
(
    input  wire logic [mbb_pkg::POS_W-1:0] lane_idx,
    input  wire logic [8:0]                col0,
    input  wire logic [7:0]                base,
    input  wire logic [8:0]                width_held,
    input  wire logic                      data_bit,
    output mbb_pkg::lane_t                 lane
);

    localparam logic [9:0] SW_LIMIT = 10'(mbb_pkg::SCREEN_WIDTH);

    logic [8:0] x;
    logic [8:0] col;
    logic [3:0] carry_sum;

    always_comb
    begin
        x         = {1'b0, base} + {6'd0, lane_idx};
        col       = col0 + {6'd0, lane_idx};
        // pixel spills into the second frame byte when the low bits wrap
        carry_sum = {1'b0, col0[2:0]} + {1'b0, lane_idx};
        lane.hit  = (x < width_held) && ({1'b0, col} < SW_LIMIT);
        lane.in_b = carry_sum[3];
        lane.pos  = col[2:0];
        lane.src  = data_bit;
    end

endmodule

`default_nettype wire

@@ design/mbb_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mbb_merge
(
    input  wire mbb_pkg::lane_t [mbb_pkg::NUM_LANES-1:0] lanes,
    input  wire logic                                    row_ok,
    input  wire logic                                    a_ok,
    input  wire logic                                    b_ok,
    output mbb_pkg::merge_t                              merged
);

    logic [mbb_pkg::POS_W-1:0] bit_idx;

    always_comb
    begin
        merged  = '0;
        bit_idx = '0;
        for (int i = 0; i < mbb_pkg::NUM_LANES; i++)
        begin
            // leftmost pixel sits in the msb
            bit_idx = mbb_pkg::POS_W'(mbb_pkg::TOP_BIT) - lanes[i].pos;
            if (lanes[i].hit && row_ok)
            begin
                if (lanes[i].in_b)
                begin
                    if (b_ok)
                    begin
                        merged.mask_b[bit_idx] = 1'b1;
                        merged.bits_b[bit_idx] = lanes[i].src;
                    end
                end
                else if (a_ok)
                begin
                    merged.mask_a[bit_idx] = 1'b1;
                    merged.bits_a[bit_idx] = lanes[i].src;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ design/mono_bitmap_blit_raster_op.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  signals                                  accepted when
// in       op pos_x pos_y blit_width blit_height    in_valid & in_ready
//          mode data address
// out      read_data blit_done                      out_valid & out_ready
//
// start, frame write and a source byte with no blit running finish in the idle state; a
// frame read passes through S_RD; a source byte of a running blit steps through S_WR_A
// and S_WR_B (read first frame byte, write it while reading the second, write the second)
// as the single write port and single read port of the frame store allow.
// after reset a clearing pass zeroes all 1920 frame bytes, in_ready low.
// a result waiting on out_ready holds the block in its emit state until taken.

module mono_bitmap_blit_raster_op
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] op,
    input  wire logic [7:0] pos_x,
    input  wire logic [7:0] pos_y,
    input  wire logic [8:0] blit_width,
    input  wire logic [8:0] blit_height,
    input  wire logic [1:0] mode,
    input  wire logic [7:0] data,
    input  wire logic [10:0] address,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      read_data,
    output logic            blit_done
);

    localparam int AW = mbb_pkg::ADDR_W;
    localparam int IW = mbb_pkg::IDX_W;
    localparam logic [AW-1:0] CLR_LAST  = AW'(mbb_pkg::FRAME_DEPTH - 1);
    localparam logic [AW-1:0] DEPTH_A   = AW'(mbb_pkg::FRAME_DEPTH);
    localparam logic [IW-1:0] DEPTH_I   = IW'(mbb_pkg::FRAME_DEPTH);
    localparam logic [9:0]    SH_LIMIT  = 10'(mbb_pkg::SCREEN_HEIGHT);
    localparam logic [8:0]    SIZE_MAX  = 9'(mbb_pkg::MAX_SIZE);
    localparam logic [8:0]    BYTE_PIX  = 9'(mbb_pkg::NUM_LANES);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_WR_A  = 6'b000100,
        S_WR_B  = 6'b001000,
        S_RD    = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;

    logic [7:0]      origin_x_reg, origin_y_reg;
    logic [8:0]      width_held_reg, height_held_reg;
    logic [1:0]      mode_held_reg;
    logic [7:0]      row_count_reg;
    logic [4:0]      byte_col_reg;
    logic            blit_active_reg;
    logic            done_pend_reg;

    mbb_pkg::merge_t mg_reg;
    logic [AW-1:0]   a_addr_reg, b_addr_reg;
    logic            addr_ok_reg;
    logic            res_rd_reg;
    logic [7:0]      mem_q_reg;
    logic            out_valid_reg;
    logic [7:0]      read_data_reg;
    logic            blit_done_reg;

    logic [7:0]      mem [mbb_pkg::FRAME_DEPTH];

    logic            accept;
    logic            out_free;
    logic            load_out;
    logic            addr_in_ok;
    logic [7:0]      base;
    logic [8:0]      col0;
    logic [8:0]      row;
    logic            row_ok;
    logic [IW-1:0]   idx_a, idx_b;
    logic            a_ok, b_ok;
    logic            last_col, last_row;
    logic [8:0]      w_sat, h_sat;

    mbb_pkg::lane_t [mbb_pkg::NUM_LANES-1:0] lanes;
    mbb_pkg::merge_t merged;

    logic            we, re;
    logic [AW-1:0]   waddr, raddr;
    logic [7:0]      wdata;
    logic [7:0]      rop_a, rop_b, new_a, new_b;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || out_ready;
    assign addr_in_ok = (address < DEPTH_A);

    // destination geometry of the next source byte
    assign base     = {byte_col_reg, 3'b000};
    assign col0     = {1'b0, origin_x_reg} + {1'b0, base};
    assign row      = {1'b0, origin_y_reg} + {1'b0, row_count_reg};
    assign row_ok   = ({1'b0, row} < SH_LIMIT);
    assign idx_a    = IW'(mbb_pkg::LINE_BYTES * row) + IW'(col0[8:3]);
    assign idx_b    = idx_a + IW'(1);
    assign a_ok     = (idx_a < DEPTH_I);
    assign b_ok     = (idx_b < DEPTH_I);
    assign last_col = (({1'b0, base} + BYTE_PIX) >= width_held_reg);
    assign last_row = (({1'b0, row_count_reg} + 9'd1) >= height_held_reg);
    assign w_sat    = (blit_width > SIZE_MAX) ? SIZE_MAX : blit_width;
    assign h_sat    = (blit_height > SIZE_MAX) ? SIZE_MAX : blit_height;

    for (genvar i = 0; i < mbb_pkg::NUM_LANES; i++)
    begin : g_lane
        mbb_lane u_lane
        (
            .lane_idx   (mbb_pkg::POS_W'(i)),
            .col0       (col0),
            .base       (base),
            .width_held (width_held_reg),
            .data_bit   (data[mbb_pkg::TOP_BIT - i]),
            .lane       (lanes[i])
        );
    end

    mbb_merge u_merge
    (
        .lanes  (lanes),
        .row_ok (row_ok),
        .a_ok   (a_ok),
        .b_ok   (b_ok),
        .merged (merged)
    );

    // raster op on the old frame byte, only masked pixels change
    always_comb
    begin
        case (mode_held_reg)
            mbb_pkg::MODE_COPY:
            begin
                rop_a = mg_reg.bits_a;
                rop_b = mg_reg.bits_b;
            end
            mbb_pkg::MODE_AND:
            begin
                rop_a = mg_reg.bits_a & mem_q_reg;
                rop_b = mg_reg.bits_b & mem_q_reg;
            end
            mbb_pkg::MODE_OR:
            begin
                rop_a = mg_reg.bits_a | mem_q_reg;
                rop_b = mg_reg.bits_b | mem_q_reg;
            end
            default:
            begin
                rop_a = 8'd0;
                rop_b = 8'd0;
            end
        endcase
        new_a = (mem_q_reg & ~mg_reg.mask_a) | (rop_a & mg_reg.mask_a);
        new_b = (mem_q_reg & ~mg_reg.mask_b) | (rop_b & mg_reg.mask_b);
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        we           = 1'b0;
        re           = 1'b0;
        waddr        = clr_cnt_reg;
        raddr        = address;
        wdata        = 8'd0;
        load_out     = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        mbb_pkg::OP_SRC:
                        begin
                            if (blit_active_reg)
                            begin
                                re         = |merged.mask_a;
                                raddr      = idx_a[AW-1:0];
                                state_next = S_WR_A;
                            end
                        end
                        mbb_pkg::OP_READ:
                        begin
                            re         = addr_in_ok;
                            state_next = S_RD;
                        end
                        mbb_pkg::OP_WRITE:
                        begin
                            we    = addr_in_ok;
                            waddr = address;
                            wdata = data;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WR_A:
            begin
                we         = |mg_reg.mask_a;
                waddr      = a_addr_reg;
                wdata      = new_a;
                re         = |mg_reg.mask_b;
                raddr      = b_addr_reg;
                state_next = S_WR_B;
            end
            S_WR_B:
            begin
                we    = |mg_reg.mask_b;
                waddr = b_addr_reg;
                wdata = new_b;
                if (!done_pend_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_RD, S_EMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            mem_q_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            origin_x_reg    <= 8'd0;
            origin_y_reg    <= 8'd0;
            width_held_reg  <= 9'd1;
            height_held_reg <= 9'd1;
            mode_held_reg   <= mbb_pkg::MODE_COPY;
            row_count_reg   <= 8'd0;
            byte_col_reg    <= 5'd0;
            blit_active_reg <= 1'b0;
            done_pend_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept && op == mbb_pkg::OP_START)
            begin
                origin_x_reg    <= pos_x;
                origin_y_reg    <= pos_y;
                width_held_reg  <= w_sat;
                height_held_reg <= h_sat;
                mode_held_reg   <= mode;
                row_count_reg   <= 8'd0;
                byte_col_reg    <= 5'd0;
                blit_active_reg <= (w_sat != 9'd0) && (h_sat != 9'd0);
            end
            else if (accept && op == mbb_pkg::OP_SRC && blit_active_reg)
            begin
                done_pend_reg <= 1'b0;
                if (last_col)
                begin
                    byte_col_reg <= 5'd0;
                    if (last_row)
                    begin
                        row_count_reg   <= 8'd0;
                        blit_active_reg <= 1'b0;
                        done_pend_reg   <= 1'b1;
                    end
                    else
                    begin
                        row_count_reg <= row_count_reg + 8'd1;
                    end
                end
                else
                begin
                    byte_col_reg <= byte_col_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mg_reg      <= merged;
            a_addr_reg  <= idx_a[AW-1:0];
            b_addr_reg  <= idx_b[AW-1:0];
            addr_ok_reg <= addr_in_ok;
            res_rd_reg  <= (op == mbb_pkg::OP_READ);
        end
        if (load_out)
        begin
            read_data_reg <= (res_rd_reg && addr_ok_reg) ? mem_q_reg : 8'd0;
            blit_done_reg <= !res_rd_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign blit_done = blit_done_reg;

`ifndef SYNTHESIS
    a_done_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && blit_done) |-> (read_data == 8'd0))
        else $error("done item carries frame data");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("pending item not moved to output");

    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && clr_cnt_reg == CLR_LAST) |=> (state_reg == S_IDLE))
        else $error("clearing pass did not finish");
`endif

endmodule

`default_nettype wire
